// ===== rtl/core/image_orient_brightness_buffer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the oriented frame buffer core
// Shared implication checks, clocked on clk and masked during reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ORIENT_BRIGHTNESS_BUFFER_CORE_DEFINES_SVH
`define IMAGE_ORIENT_BRIGHTNESS_BUFFER_CORE_DEFINES_SVH

// same-cycle implication
`define IOBB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iobb: same-cycle check failed");

// next-cycle implication
`define IOBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iobb: next-cycle check failed");

`endif

// ===== rtl/core/iobb_pkg.sv =====
// ----------------------------------------------------------------------------
// iobb_pkg
// Types, orientation codes and saturation helpers for the frame buffer.
// ----------------------------------------------------------------------------
package iobb_pkg;

  localparam logic [2:0] ORI_NONE      = 3'd0;
  localparam logic [2:0] ORI_TRANSPOSE = 3'd1;
  localparam logic [2:0] ORI_ROT90     = 3'd2;
  localparam logic [2:0] ORI_ROT180    = 3'd3;
  localparam logic [2:0] ORI_ROT270    = 3'd4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef struct packed {
    logic [7:0]        image_rows;
    logic [7:0]        image_cols;
    logic [2:0]        orientation;
    logic signed [8:0] brightness_offset;
  } cfg_t;

  // store access issued for an accepted word, plus the output position
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
    logic [6:0] out_row;
    logic [6:0] out_col;
    logic       frame_last;
  } mem_cmd_t;

  function automatic logic [7:0] clamp_s16(logic signed [15:0] v);
    logic [7:0] r;
    if (v < 16'sd0) r = 8'd0;
    else if (v > 16'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  function automatic logic [7:0] clamp_s10(logic signed [9:0] v);
    logic [7:0] r;
    if (v < 10'sd0) r = 8'd0;
    else if (v > 10'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/iobb_ram.sv =====
// ----------------------------------------------------------------------------
// iobb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module iobb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/iobb_agen.sv =====
// ----------------------------------------------------------------------------
// iobb_agen
// Load and fetch position counters and store address generation.
// ----------------------------------------------------------------------------
module iobb_agen
  import iobb_pkg::*;
#(
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WIDTH  = 128
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  cfg_t                                     cfg,
  input  logic                                     accept,
  input  logic                                     action,
  input  logic signed [15:0]                       pixel_in,
  output mem_cmd_t                                 cmd,
  output logic [$clog2(MAX_HEIGHT*MAX_WIDTH)-1:0]  addr
);

  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH);
  localparam int PW = (HW > WW) ? HW : WW;
  localparam int DW = PW + 1;
  localparam int AW = $clog2(MAX_HEIGHT * MAX_WIDTH);

  logic [PW-1:0] load_row, load_row_next, load_col, load_col_next;
  logic [PW-1:0] read_row, read_row_next, read_col, read_col_next;

  logic [DW-1:0] nr, nc, orows, ocols;
  logic          swap;
  logic [PW-1:0] lr, lc, r, c, i, j;
  logic [DW-1:0] lc_inc, lr_inc, c_inc, r_inc;
  logic [DW-1:0] mi, mj;
  logic [31:0]   lin;

  // effective dimensions: zero acts as one, large values clip to the store
  always_comb begin
    if (cfg.image_rows == 8'd0) nr = DW'(1);
    else if (32'(cfg.image_rows) > MAX_HEIGHT) nr = DW'(MAX_HEIGHT);
    else nr = DW'(cfg.image_rows);
    if (cfg.image_cols == 8'd0) nc = DW'(1);
    else if (32'(cfg.image_cols) > MAX_WIDTH) nc = DW'(MAX_WIDTH);
    else nc = DW'(cfg.image_cols);
  end

  assign swap  = (cfg.orientation == ORI_TRANSPOSE) || (cfg.orientation == ORI_ROT90) ||
                 (cfg.orientation == ORI_ROT270);
  assign orows = swap ? nc : nr;
  assign ocols = swap ? nr : nc;

  // restart at the origin if a register change left a position outside
  always_comb begin
    if ({1'b0, load_row} >= nr || {1'b0, load_col} >= nc) begin
      lr = '0;
      lc = '0;
    end else begin
      lr = load_row;
      lc = load_col;
    end
    if ({1'b0, read_row} >= orows || {1'b0, read_col} >= ocols) begin
      r = '0;
      c = '0;
    end else begin
      r = read_row;
      c = read_col;
    end
  end

  // output position to stored pixel
  always_comb begin
    case (cfg.orientation)
      ORI_TRANSPOSE: begin
        mi = {1'b0, c};
        mj = {1'b0, r};
      end
      ORI_ROT90: begin
        mi = nr - DW'(1) - {1'b0, c};
        mj = {1'b0, r};
      end
      ORI_ROT180: begin
        mi = nr - DW'(1) - {1'b0, r};
        mj = nc - DW'(1) - {1'b0, c};
      end
      ORI_ROT270: begin
        mi = {1'b0, c};
        mj = nc - DW'(1) - {1'b0, r};
      end
      default: begin
        mi = {1'b0, r};
        mj = {1'b0, c};
      end
    endcase
    i = mi[PW-1:0];
    j = mj[PW-1:0];
  end

  always_comb begin
    if (action == ACT_FETCH) begin
      lin = 32'(int'(i) * MAX_WIDTH + int'(j));
    end else begin
      lin = 32'(int'(lr) * MAX_WIDTH + int'(lc));
    end
    addr = lin[AW-1:0];
  end

  assign cmd.we         = accept && (action == ACT_LOAD);
  assign cmd.re         = accept && (action == ACT_FETCH);
  assign cmd.wdata      = clamp_s16(pixel_in);
  assign cmd.out_row    = 7'(r);
  assign cmd.out_col    = 7'(c);
  assign cmd.frame_last = ({1'b0, r} == orows - DW'(1)) && ({1'b0, c} == ocols - DW'(1));

  assign lc_inc = {1'b0, lc} + DW'(1);
  assign lr_inc = {1'b0, lr} + DW'(1);
  assign c_inc  = {1'b0, c} + DW'(1);
  assign r_inc  = {1'b0, r} + DW'(1);

  always_comb begin
    load_row_next = load_row;
    load_col_next = load_col;
    read_row_next = read_row;
    read_col_next = read_col;
    if (cmd.we) begin
      if (lc_inc >= nc) begin
        load_col_next = '0;
        load_row_next = (lr_inc >= nr) ? '0 : lr_inc[PW-1:0];
      end else begin
        load_col_next = lc_inc[PW-1:0];
        load_row_next = lr;
      end
    end
    if (cmd.re) begin
      if (c_inc >= ocols) begin
        read_col_next = '0;
        read_row_next = (r_inc >= orows) ? '0 : r_inc[PW-1:0];
      end else begin
        read_col_next = c_inc[PW-1:0];
        read_row_next = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_row <= '0;
      load_col <= '0;
      read_row <= '0;
      read_col <= '0;
    end else begin
      load_row <= load_row_next;
      load_col <= load_col_next;
      read_row <= read_row_next;
      read_col <= read_col_next;
    end
  end

endmodule

// ===== rtl/core/image_orient_brightness_buffer_core.sv =====
// ----------------------------------------------------------------------------
// image_orient_brightness_buffer_core
// Grayscale frame buffer: raster loads, oriented fetches with brightness.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | action, pixel_in
//  out     | source    | out_valid/out_stall| pixel_out, out_row, out_col, frame_last
//  cfg     | APB slave | psel/penable/pready| paddr, pwdata, prdata
//
// One word per cycle on the input while results drain; a fetch result passes
// through the store read register, then the offset and saturation into the
// output register. Loads give no result. Input stalls only when a fetched
// pixel waits behind a stalled output word. Reset clears positions and valid
// flags, sets the config to 1x1 with no offset; the pixel store is not cleared.
`include "image_orient_brightness_buffer_core_defines.svh"

module image_orient_brightness_buffer_core
  import iobb_pkg::*;
#(
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WIDTH  = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [15:0] pixel_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         pixel_out,
  output logic [6:0]         out_row,
  output logic [6:0]         out_col,
  output logic               frame_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_ORIENT = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  cfg_t          cfg;
  mem_cmd_t      cmd;
  logic [AW-1:0] addr;
  logic [7:0]    rdata;
  logic          in_acc, cfg_wr;

  logic       s1_valid, s1_move;
  logic [6:0] s1_row, s1_col;
  logic       s1_last;

  // ---- configuration ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_rows        <= 8'd1;
      cfg.image_cols        <= 8'd1;
      cfg.orientation       <= ORI_NONE;
      cfg.brightness_offset <= 9'sd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROWS:   cfg.image_rows        <= pwdata[7:0];
        REG_COLS:   cfg.image_cols        <= pwdata[7:0];
        REG_ORIENT: cfg.orientation       <= pwdata[2:0];
        REG_OFFSET: cfg.brightness_offset <= signed'(pwdata[8:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS:   prdata = {24'd0, cfg.image_rows};
      REG_COLS:   prdata = {24'd0, cfg.image_cols};
      REG_ORIENT: prdata = {29'd0, cfg.orientation};
      REG_OFFSET: prdata = {23'd0, cfg.brightness_offset};
      default:    prdata = '0;
    endcase
  end

  // ---- address generation and store ----
  assign in_acc = in_valid && !in_stall;

  iobb_agen #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_agen (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (in_acc),
    .action  (action),
    .pixel_in(pixel_in),
    .cmd     (cmd),
    .addr    (addr)
  );

  iobb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.we),
    .waddr(addr),
    .wdata(cmd.wdata),
    .re   (cmd.re),
    .raddr(addr),
    .rdata(rdata)
  );

  // ---- read stage and output word ----
  // rdata holds while s1 waits, as no read is issued until it moves on
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.re) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re) begin
      s1_row  <= cmd.out_row;
      s1_col  <= cmd.out_col;
      s1_last <= cmd.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pixel_out  <= clamp_s10(signed'({2'b00, rdata}) +
                              {cfg.brightness_offset[8], cfg.brightness_offset});
      out_row    <= s1_row;
      out_col    <= s1_col;
      frame_last <= s1_last;
    end
  end

  // ---- checks ----
  `IOBB_ASSERT_NEXT(a_fetch_reaches_s1, cmd.re, s1_valid)
  `IOBB_ASSERT_SAME(a_stall_when_blocked, s1_valid && out_valid && out_stall, in_stall)
  `IOBB_ASSERT_SAME(a_single_store_access, cmd.we, !cmd.re)
  `IOBB_ASSERT_NEXT(a_s1_to_output, s1_move, out_valid)

endmodule
